// ----- sv/mmn_pkg.sv -----
// Package for the min-max normalizer: field widths, fixed-point constants
// and the sequencer state type. No dependencies.
`default_nettype none

package mmn_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int COL_W     = 4;
   localparam int SPAN_W    = 31;
   localparam int FRAC_BITS = 16;
   localparam int NORM_W    = 17;
   localparam int DIFF_W    = 33;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic [NORM_W-1:0]          Q_ONE      = 17'h1_0000;
   localparam logic [SPAN_W-1:0]          SPAN_RESET = 31'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic FUNC_OBSERVE   = 1'b0;
   localparam logic FUNC_NORMALIZE = 1'b1;

endpackage

`default_nettype wire

// ----- sv/mmn_req_if.sv -----
// Request channel of the min-max normalizer: valid/ready handshake with the
// function code, column index and sample. Depends on mmn_pkg.
`default_nettype none

interface mmn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic [mmn_pkg::COL_W-1:0]            column;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, func, column, sample, input ready);
   modport sink   (input valid, func, column, sample, output ready);
endinterface

`default_nettype wire

// ----- sv/mmn_rsp_if.sv -----
// Response channel of the min-max normalizer: valid/ready handshake with the
// normalized value and the flat-column flag. Depends on mmn_pkg.
`default_nettype none

interface mmn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mmn_pkg::NORM_W-1:0]   norm_value;
   logic                         flat_column;

   modport source (output valid, norm_value, flat_column, input ready);
   modport sink   (input valid, norm_value, flat_column, output ready);
endinterface

`default_nettype wire

// ----- sv/mmn_div.sv -----
// Bit-serial restoring divider producing one quotient bit per cycle for the
// fraction num * 2^16 / den with num below den. Depends on mmn_pkg.
`default_nettype none

module mmn_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [mmn_pkg::SAMPLE_W-1:0]      num,
   input  wire logic [mmn_pkg::SAMPLE_W-1:0]      den,
   output      logic                              done,
   output      logic [mmn_pkg::FRAC_BITS-1:0]     quot
);

   localparam int CNT_W = $clog2(mmn_pkg::FRAC_BITS + 1);

   logic [mmn_pkg::SAMPLE_W-1:0]  rem_ff;
   logic [mmn_pkg::SAMPLE_W-1:0]  rem_in;
   logic [mmn_pkg::SAMPLE_W-1:0]  den_ff;
   logic [mmn_pkg::FRAC_BITS-1:0] quot_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [mmn_pkg::SAMPLE_W:0]    shifted;
   logic [mmn_pkg::SAMPLE_W:0]    diff;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = ~diff[mmn_pkg::SAMPLE_W];
      rem_in  = ge ? diff[mmn_pkg::SAMPLE_W-1:0] : shifted[mmn_pkg::SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(mmn_pkg::FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[mmn_pkg::FRAC_BITS-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ----- sv/min_max_normalizer_core.sv -----
// Top level of the min-max normalizer: column bound storage, sequencer and
// output register. Depends on mmn_pkg, mmn_req_if, mmn_rsp_if and mmn_div.
//
// Each column keeps a running minimum and maximum. An observe transaction
// folds its sample into its column's bounds in the load state and returns
// nothing. A normalize transaction returns (sample - min) / (max - min) as
// an unsigned Q1.16 fraction, saturated to 0..65536, or zero with the flat
// flag when the span is below min_span, the column was never observed or
// its index is out of range. A result that saturates or is flat is set in
// the check state; any other comes from the bit-serial divider, which
// produces one of sixteen quotient bits per cycle. The output register lets
// the next request be accepted while a finished response still waits. The
// bounds live in a memory of MAX_COLS entries with one valid bit each, so
// no clearing pass follows reset.
`default_nettype none

module min_max_normalizer_core #(
   parameter int MAX_COLS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [mmn_pkg::SPAN_W-1:0]    csr_wdata,
   mmn_req_if.sink                            req_if,
   mmn_rsp_if.source                          rsp_if
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   mmn_pkg::state_type state_ff;
   mmn_pkg::state_type state_in;

   logic [mmn_pkg::SPAN_W-1:0]           min_span_ff;

   logic signed [mmn_pkg::SAMPLE_W-1:0]  mem_min [MAX_COLS];
   logic signed [mmn_pkg::SAMPLE_W-1:0]  mem_max [MAX_COLS];
   logic [MAX_COLS-1:0]                  vld_ff;

   logic [IDX_W+mmn_pkg::COL_W-1:0]      col_ext;
   logic [IDX_W-1:0]                     req_idx;
   logic                                 req_inrange;
   logic                                 req_fire;

   logic                                 func_ff;
   logic [IDX_W-1:0]                     idx_ff;
   logic                                 inrange_ff;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  sample_ff;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  rd_min_ff;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  rd_max_ff;
   logic                                 rd_vld_ff;

   logic signed [mmn_pkg::SAMPLE_W-1:0]  eff_min;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  eff_max;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  new_min;
   logic signed [mmn_pkg::SAMPLE_W-1:0]  new_max;

   logic signed [mmn_pkg::DIFF_W-1:0]    span_ff;
   logic signed [mmn_pkg::DIFF_W-1:0]    num_ff;
   logic signed [mmn_pkg::DIFF_W-1:0]    min_span_ext;

   logic                                 is_flat;
   logic                                 is_low;
   logic                                 is_high;

   logic [mmn_pkg::NORM_W-1:0]           res_val_ff;
   logic [mmn_pkg::NORM_W-1:0]           res_val_in;
   logic                                 res_flat_ff;
   logic                                 res_flat_in;
   logic                                 res_set;

   logic                                 rsp_valid_ff;
   logic [mmn_pkg::NORM_W-1:0]           rsp_val_ff;
   logic                                 rsp_flat_ff;
   logic                                 out_free;

   logic                                 req_ready;
   logic                                 do_write;
   logic                                 div_start;
   logic                                 out_load;
   logic                                 div_done;
   logic [mmn_pkg::FRAC_BITS-1:0]        div_quot;

   always_comb begin
      col_ext     = {{IDX_W{1'b0}}, req_if.column};
      req_idx     = col_ext[IDX_W-1:0];
      req_inrange = ({3'b000, req_if.column} < 7'(MAX_COLS));
      req_fire    = req_if.valid & req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_span_ff <= mmn_pkg::SPAN_RESET;
      end else if (csr_we) begin
         min_span_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff    <= req_if.func;
         idx_ff     <= req_idx;
         inrange_ff <= req_inrange;
         sample_ff  <= req_if.sample;
         rd_min_ff  <= mem_min[req_idx];
         rd_max_ff  <= mem_max[req_idx];
         rd_vld_ff  <= vld_ff[req_idx];
      end
   end

   always_comb begin
      eff_min = rd_vld_ff ? rd_min_ff : mmn_pkg::SAMPLE_MAX;
      eff_max = rd_vld_ff ? rd_max_ff : mmn_pkg::SAMPLE_MIN;
      new_min = (sample_ff < eff_min) ? sample_ff : eff_min;
      new_max = (sample_ff > eff_max) ? sample_ff : eff_max;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_min[idx_ff] <= new_min;
         mem_max[idx_ff] <= new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (do_write) begin
         vld_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mmn_pkg::S_LOAD) begin
         span_ff <= {eff_max[mmn_pkg::SAMPLE_W-1], eff_max}
                    - {eff_min[mmn_pkg::SAMPLE_W-1], eff_min};
         num_ff  <= {sample_ff[mmn_pkg::SAMPLE_W-1], sample_ff}
                    - {eff_min[mmn_pkg::SAMPLE_W-1], eff_min};
      end
   end

   always_comb begin
      min_span_ext = {2'b00, min_span_ff};
      is_flat      = ~inrange_ff | (span_ff < min_span_ext);
      is_low       = num_ff[mmn_pkg::DIFF_W-1] | (num_ff == '0);
      is_high      = (num_ff >= span_ff);
   end

   mmn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff[mmn_pkg::SAMPLE_W-1:0]),
      .den   (span_ff[mmn_pkg::SAMPLE_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmn_pkg::S_IDLE: begin
            if (req_fire) state_in = mmn_pkg::S_LOAD;
         end
         mmn_pkg::S_LOAD: begin
            if (func_ff == mmn_pkg::FUNC_NORMALIZE) state_in = mmn_pkg::S_CHECK;
            else                                    state_in = mmn_pkg::S_IDLE;
         end
         mmn_pkg::S_CHECK: begin
            if (is_flat || is_low || is_high) state_in = mmn_pkg::S_DONE;
            else                              state_in = mmn_pkg::S_DIV;
         end
         mmn_pkg::S_DIV: begin
            if (div_done) state_in = mmn_pkg::S_DONE;
         end
         mmn_pkg::S_DONE: begin
            if (out_free) state_in = mmn_pkg::S_IDLE;
         end
         default: state_in = mmn_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      do_write    = 1'b0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      res_set     = 1'b0;
      res_val_in  = '0;
      res_flat_in = 1'b0;
      case (state_ff)
         mmn_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         mmn_pkg::S_LOAD: begin
            do_write = (func_ff == mmn_pkg::FUNC_OBSERVE) & inrange_ff;
         end
         mmn_pkg::S_CHECK: begin
            res_set = 1'b1;
            if (is_flat) begin
               res_flat_in = 1'b1;
            end else if (is_low) begin
               res_val_in = '0;
            end else if (is_high) begin
               res_val_in = mmn_pkg::Q_ONE;
            end else begin
               res_set   = 1'b0;
               div_start = 1'b1;
            end
         end
         mmn_pkg::S_DIV: begin
            if (div_done) begin
               res_set    = 1'b1;
               res_val_in = {1'b0, div_quot};
            end
         end
         mmn_pkg::S_DONE: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmn_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_set) begin
         res_val_ff  <= res_val_in;
         res_flat_ff <= res_flat_in;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_val_ff  <= res_val_ff;
         rsp_flat_ff <= res_flat_ff;
      end
   end

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.norm_value  = rsp_val_ff;
   assign rsp_if.flat_column = rsp_flat_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mmn_pkg::S_DONE))
      else $error("Response raised outside the completion state.");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == mmn_pkg::S_DIV)
      else $error("Divider finished while the sequencer was not waiting.");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == mmn_pkg::S_LOAD)
      else $error("Accepted transaction did not start a bounds read.");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flat_ff |-> rsp_val_ff == '0)
      else $error("Flat column response carries a nonzero value.");

   a_val_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_val_ff <= mmn_pkg::Q_ONE)
      else $error("Normalized value exceeds one.");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for min_max_normalizer_core: a scoreboard class tracks the
// column bounds and predicts every normalize response, and plain tasks drive the ports.
// Depends on mmn_pkg, mmn_req_if, mmn_rsp_if and the normalizer RTL.

typedef struct packed {
   logic [mmn_pkg::NORM_W-1:0] norm_value;
   logic                       flat_column;
} norm_result_type;

class minmax_scoreboard;
   localparam int NUM_COLS = 16;

   logic signed [mmn_pkg::SAMPLE_W-1:0] col_min [NUM_COLS];
   logic signed [mmn_pkg::SAMPLE_W-1:0] col_max [NUM_COLS];
   logic [mmn_pkg::SPAN_W-1:0]          min_span;
   norm_result_type                     pending_norms [$];
   int                                  errors;

   function new();
      for (int i = 0; i < NUM_COLS; i++) begin
         col_min[i] = mmn_pkg::SAMPLE_MAX;
         col_max[i] = mmn_pkg::SAMPLE_MIN;
      end
      min_span = mmn_pkg::SPAN_RESET;
      errors   = 0;
   endfunction

   function void set_min_span(logic [mmn_pkg::SPAN_W-1:0] value);
      min_span = value;
   endfunction

   function int outstanding();
      return pending_norms.size();
   endfunction

   function norm_result_type scaled_value(logic signed [mmn_pkg::SAMPLE_W-1:0] sample,
                                          logic [mmn_pkg::COL_W-1:0] column);
      norm_result_type result;
      longint          span;
      longint          num;
      result.norm_value  = '0;
      result.flat_column = 1'b1;
      if (int'(column) < NUM_COLS) begin
         span = longint'(col_max[column]) - longint'(col_min[column]);
         num  = longint'(sample) - longint'(col_min[column]);
         if (span >= longint'(min_span)) begin
            result.flat_column = 1'b0;
            if (num <= 0)
               result.norm_value = '0;
            else if (num >= span || span <= 0)
               result.norm_value = mmn_pkg::Q_ONE;
            else
               result.norm_value = mmn_pkg::NORM_W'((num * 65536) / span);
         end
      end
      return result;
   endfunction

   function void note_request(logic func, logic [mmn_pkg::COL_W-1:0] column,
                              logic signed [mmn_pkg::SAMPLE_W-1:0] sample);
      if (func == mmn_pkg::FUNC_NORMALIZE) begin
         pending_norms.push_back(scaled_value(sample, column));
      end else if (int'(column) < NUM_COLS) begin
         if (sample < col_min[column])
            col_min[column] = sample;
         if (sample > col_max[column])
            col_max[column] = sample;
      end
   endfunction

   task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task check_response(logic [mmn_pkg::NORM_W-1:0] norm_value, logic flat_column);
      norm_result_type want;
      if (pending_norms.size() == 0) begin
         report_mismatch($sformatf("response norm=%0d flat=%0b with none pending",
                                   norm_value, flat_column));
      end else begin
         want = pending_norms.pop_front();
         if (norm_value !== want.norm_value)
            report_mismatch($sformatf("norm_value %0d, predicted %0d",
                                      norm_value, want.norm_value));
         if (flat_column !== want.flat_column)
            report_mismatch($sformatf("flat_column %0b, predicted %0b",
                                      flat_column, want.flat_column));
      end
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_COLS     = 16;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLDOFF_LEN  = 400;
   localparam int PHASE_ITEMS  = 120;
   localparam logic [mmn_pkg::SPAN_W-1:0] SPAN_MAX = 31'h7FFF_FFFF;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [mmn_pkg::SPAN_W-1:0] csr_wdata;

   mmn_req_if req ();
   mmn_rsp_if rsp ();

   minmax_scoreboard sb;
   bit               busy_mode;
   bit               holdoff_request;
   int               cycle_count;

   min_max_normalizer_core #(.MAX_COLS(NUM_COLS)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req),
      .rsp_if    (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!busy_mode || r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic offer_sample(logic func, logic [mmn_pkg::COL_W-1:0] column,
                               logic signed [mmn_pkg::SAMPLE_W-1:0] sample);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.func   <= func;
      req.column <= column;
      req.sample <= sample;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic offer_random();
      logic                                func;
      logic [mmn_pkg::COL_W-1:0]           column;
      logic signed [mmn_pkg::SAMPLE_W-1:0] sample;
      int                                  center;
      func   = ($urandom_range(0, 99) < 40) ? mmn_pkg::FUNC_OBSERVE
                                            : mmn_pkg::FUNC_NORMALIZE;
      column = mmn_pkg::COL_W'($urandom_range(0, NUM_COLS - 1));
      center = (int'(column) - 8) * (1 << 24);
      case ($urandom_range(0, 9))
         0, 1:    sample = $urandom;
         2, 3, 4: sample = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: sample = center + int'($urandom_range(0, 1 << 23)) - (1 << 22);
      endcase
      offer_sample(func, column, sample);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_min_span(logic [mmn_pkg::SPAN_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_min_span(value);
   endtask

   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            stall_left      = HOLDOFF_LEN;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (!busy_mode) begin
            rsp.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp.ready <= 1'b1;
            end else begin
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
               rsp.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            sb.check_response(rsp.norm_value, rsp.flat_column);
         if (req.valid && req.ready)
            sb.note_request(req.func, req.column, req.sample);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [mmn_pkg::SPAN_W-1:0] phase_span [6];
      sb              = new();
      busy_mode       = 1'b1;
      holdoff_request = 1'b0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req.valid       = 1'b0;
      req.func        = mmn_pkg::FUNC_OBSERVE;
      req.column      = '0;
      req.sample      = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Empty columns, then bounds on column 0 spanning 0.0 to 4.0.
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, 32'sd0);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd15, mmn_pkg::SAMPLE_MAX);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd0, 32'sd0);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd0, 32'sd262144);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, -32'sd1);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, 32'sd0);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, 32'sd65536);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, 32'sd262144);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, mmn_pkg::SAMPLE_MAX);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, mmn_pkg::SAMPLE_MIN);
      // Full-range column and a span of three to exercise truncation.
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd15, mmn_pkg::SAMPLE_MIN);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd15, mmn_pkg::SAMPLE_MAX);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd15, 32'sd0);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd15, -32'sd1);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd2, 32'sd0);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd2, 32'sd3);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd2, 32'sd1);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd2, 32'sd2);
      offer_sample(mmn_pkg::FUNC_OBSERVE, 4'd1, 32'sd100);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd1, 32'sd100);
      wait_idle();

      // A zero span is not flat once min_span is zero; an empty column still is.
      write_min_span('0);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd1, 32'sd100);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd1, 32'sd101);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd1, 32'sd99);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd3, 32'sd0);
      wait_idle();

      write_min_span(SPAN_MAX);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd15, 32'sd0);
      offer_sample(mmn_pkg::FUNC_NORMALIZE, 4'd0, 32'sd65536);
      wait_idle();

      phase_span[0] = mmn_pkg::SPAN_W'($urandom_range(1, 1 << 20));
      phase_span[1] = '0;
      phase_span[2] = mmn_pkg::SPAN_W'($urandom);
      phase_span[3] = SPAN_MAX;
      phase_span[4] = mmn_pkg::SPAN_W'($urandom_range(1, 1 << 26));
      phase_span[5] = mmn_pkg::SPAN_RESET;
      for (int p = 0; p < 6; p++) begin
         write_min_span(phase_span[p]);
         busy_mode = (p != 4);
         if (p == 1 || p == 5)
            holdoff_request = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            offer_random();
         wait_idle();
      end

      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/mmn_pkg.sv
sv/mmn_req_if.sv
sv/mmn_rsp_if.sv
sv/mmn_div.sv
sv/min_max_normalizer_core.sv
test/testbench.sv
